FILE: hw/rtl/fir_pkg.sv
package fir_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int INDEX_W  = 6;
  localparam int TAPCNT_W = 7;
  localparam int CMD_W    = 2;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  // input item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // control shared by every cell of the chain
  typedef struct packed {
    logic shift_in;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic accum;
  } mac_ctrl_t;

endpackage

FILE: hw/rtl/fir_in_if.sv
interface fir_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [fir_pkg::CMD_W-1:0]            command;
  logic signed [fir_pkg::SAMPLE_W-1:0]  sample;
  logic [fir_pkg::INDEX_W-1:0]          tap_index;
  logic signed [fir_pkg::COEF_W-1:0]    coefficient;

  modport source (output valid, command, sample, tap_index, coefficient, input ready);
  modport sink (input valid, command, sample, tap_index, coefficient, output ready);
endinterface

FILE: hw/rtl/fir_out_if.sv
interface fir_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fir_pkg::SAMPLE_W-1:0]  filtered_sample;
  logic                                 saturated;

  modport source (output valid, filtered_sample, saturated, input ready);
  modport sink (input valid, filtered_sample, saturated, output ready);
endinterface

FILE: hw/rtl/fir_cfg_if.sv
interface fir_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fir_pkg::TAPCNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/fir_filter_audio.sv
// fir_filter_audio: direct-form FIR filter over signed 16-bit audio samples.
// sample_i takes input items: command filter shifts a sample into the history
// and starts one output; load writes one Q2.16 coefficient at tap_index; clear
// zeroes the history. Loads, clears and unused commands leave the block idle.
// cfg_i writes tap_count, the number of taps in use; it is always ready.
// A filter item is taken when the block is idle. The history and coefficient
// pairs then rotate once around a chain of MAX_TAPS cells past one multiplier,
// one tap per cycle; the sum then passes the product register, the accumulator
// and the flush and done states, and the block is ready as the result appears.
// The result sits in an output register: while result_o is stalled, loads and
// clears go on and one further filter item is computed; it then waits until
// the held result is transferred.
// Reset zeroes the history, sets tap_count to 1 and drops any pending result.
// Coefficients are not reset and must be loaded before they are used.
module fir_filter_audio #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fir_in_if.sink           sample_i,
  fir_cfg_if.sink          cfg_i,
  fir_out_if.source        result_o
);

  localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int IDX_W = (CNT_W > fir_pkg::INDEX_W) ? CNT_W : fir_pkg::INDEX_W;
  localparam int CMP_W = ((CNT_W > fir_pkg::TAPCNT_W) ? CNT_W : fir_pkg::TAPCNT_W) + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e                         state_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [fir_pkg::TAPCNT_W-1:0]   tap_count_q;
  logic                           out_vld_q;
  logic signed [fir_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                           out_sat_q;

  fir_pkg::cmd_e                  cmd;
  logic                           in_go;
  logic                           filter_go, load_go, clear_go;
  fir_pkg::cell_ctrl_t            cell_ctrl;
  fir_pkg::mac_ctrl_t             mac_ctrl;
  logic [MAX_TAPS-1:0]            coef_we;
  logic                           tap_used;
  logic signed [fir_pkg::SAMPLE_W-1:0] mac_sample;
  logic                           mac_sat;

  logic signed [fir_pkg::SAMPLE_W-1:0] hist      [MAX_TAPS];
  logic signed [fir_pkg::COEF_W-1:0]   coef      [MAX_TAPS];
  logic signed [fir_pkg::SAMPLE_W-1:0] prev_hist [MAX_TAPS];

  // input transfer and command decode
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_go          = sample_i.valid && sample_i.ready;
  assign cmd            = fir_pkg::cmd_e'(sample_i.command);

  always_comb begin
    filter_go = 1'b0;
    load_go   = 1'b0;
    clear_go  = 1'b0;
    unique case (cmd)
      fir_pkg::CMD_FILTER: filter_go = in_go;
      fir_pkg::CMD_LOAD:   load_go   = in_go;
      fir_pkg::CMD_CLEAR:  clear_go  = in_go;
      default: ;
    endcase
  end

  // configuration is always taken
  assign cfg_i.ready = 1'b1;

  // chain and mac control
  assign tap_used = (CMP_W'(cnt_q) < CMP_W'(tap_count_q));

  assign cell_ctrl.shift_in = filter_go;
  assign cell_ctrl.rotate   = (state_q == ST_MAC);
  assign cell_ctrl.clear    = clear_go;

  assign mac_ctrl.clear = filter_go;
  assign mac_ctrl.accum = (state_q == ST_MAC) && tap_used;

  // row of tap cells; cell 0 holds the newest sample and feeds the multiplier
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int Nxt = (i + 1) % MAX_TAPS;

    if (i == 0) begin : g_head
      assign prev_hist[i] = sample_i.sample;
    end else begin : g_body
      assign prev_hist[i] = hist[i-1];
    end

    assign coef_we[i] = load_go && (IDX_W'(sample_i.tap_index) == IDX_W'(i));

    fir_tap_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .coef_we_i   (coef_we[i]),
      .coef_i      (sample_i.coefficient),
      .prev_hist_i (prev_hist[i]),
      .next_hist_i (hist[Nxt]),
      .next_coef_i (coef[Nxt]),
      .hist_o      (hist[i]),
      .coef_o      (coef[i])
    );
  end

  fir_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .hist_i      (hist[0]),
    .coef_i      (coef[0]),
    .filtered_o  (mac_sample),
    .saturated_o (mac_sat)
  );

  // sequencer, tap count register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      tap_count_q  <= fir_pkg::TAPCNT_W'(1);
      out_vld_q    <= 1'b0;
      out_sample_q <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        tap_count_q <= cfg_i.data;
      end

      // a transfer empties the output register unless a new result refills it
      if (out_vld_q && result_o.ready && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (filter_go) begin
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_q || result_o.ready) begin
            out_vld_q    <= 1'b1;
            out_sample_q <= mac_sample;
            out_sat_q    <= mac_sat;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid           = out_vld_q;
  assign result_o.filtered_sample = out_sample_q;
  assign result_o.saturated       = out_sat_q;

endmodule

FILE: hw/rtl/fir_tap_cell.sv
module fir_tap_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                coef_we_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] prev_hist_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] next_hist_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   next_coef_i,
  output logic signed [fir_pkg::SAMPLE_W-1:0] hist_o,
  output logic signed [fir_pkg::COEF_W-1:0]   coef_o
);

  logic signed [fir_pkg::SAMPLE_W-1:0] hist_d, hist_q;
  logic signed [fir_pkg::COEF_W-1:0]   coef_d, coef_q;

  // history: clear, shift one place on a new sample, or rotate for the mac pass
  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.clear) begin
      hist_d = '0;
    end else if (ctrl_i.shift_in) begin
      hist_d = prev_hist_i;
    end else if (ctrl_i.rotate) begin
      hist_d = next_hist_i;
    end
  end

  // coefficient: written in place, rotates together with the history
  always_comb begin
    coef_d = coef_q;
    if (coef_we_i) begin
      coef_d = coef_i;
    end else if (ctrl_i.rotate) begin
      coef_d = next_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // coefficient holds no reset value
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign hist_o = hist_q;
  assign coef_o = coef_q;

endmodule

FILE: hw/rtl/fir_mac.sv
module fir_mac #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] hist_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef_i,
  output logic signed [fir_pkg::SAMPLE_W-1:0] filtered_o,
  output logic                                saturated_o
);

  localparam int PROD_W  = fir_pkg::PROD_W;
  localparam int GROW_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int SHIFT_W = COEF_FRAC_BITS + fir_pkg::SAMPLE_W + 1;
  localparam int ACC_W   = (GROW_W > SHIFT_W) ? GROW_W : SHIFT_W;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  shifted;

  // product of the tap at the head of the chain
  assign prod_d = PROD_W'(hist_i) * PROD_W'(coef_i);

  // accumulate registered products, cleared when a new sample starts
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.accum;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor shift of the exact sum, then clip to the sample range
  assign shifted = acc_q >>> COEF_FRAC_BITS;

  always_comb begin
    saturated_o = 1'b0;
    filtered_o  = shifted[fir_pkg::SAMPLE_W-1:0];
    if (shifted > SAT_MAX) begin
      saturated_o = 1'b1;
      filtered_o  = SAT_MAX[fir_pkg::SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      saturated_o = 1'b1;
      filtered_o  = SAT_MIN[fir_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_TAPS       = 64;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = MAX_TAPS + 8;
  localparam int PHASE_ITEMS    = 155;

  localparam int SAMPLE_W = fir_pkg::SAMPLE_W;
  localparam int COEF_W   = fir_pkg::COEF_W;
  localparam int INDEX_W  = fir_pkg::INDEX_W;
  localparam int TAPCNT_W = fir_pkg::TAPCNT_W;
  localparam int CMD_W    = fir_pkg::CMD_W;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  localparam logic signed [SAMPLE_W-1:0] SMP_POS_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SMP_NEG_MAX = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   COEF_POS_MAX = 18'sh1ffff;
  localparam logic signed [COEF_W-1:0]   COEF_NEG_MAX = 18'sh20000;
  localparam logic signed [COEF_W-1:0]   COEF_UNITY   = 18'sh10000;
  localparam logic signed [COEF_W-1:0]   COEF_NEG_LSB = 18'sh3ffff;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       sat;
  } fir_out_t;

  // filter predictor and queue of outputs still to arrive
  class fir_output_predictor;
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
    logic [INDEX_W-1:0]         wr_slot;
    logic [TAPCNT_W-1:0]        tap_count;
    fir_out_t                   expected_outputs [$];
    int                         errors;

    function new();
      foreach (history[i]) history[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      wr_slot   = '0;
      tap_count = 7'd1;
      errors    = 0;
    endfunction

    function void set_taps(logic [TAPCNT_W-1:0] v);
      tap_count = v;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // apply one accepted input transfer to the shadow state
    function void accept_item(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
                              logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] coef);
      int                 taps;
      longint             acc;
      longint             y;
      fir_out_t           res;
      logic [INDEX_W-1:0] slot;
      case (cmd)
        fir_pkg::CMD_LOAD: begin
          coefs[idx] = coef;
        end
        fir_pkg::CMD_CLEAR: begin
          foreach (history[i]) history[i] = '0;
          wr_slot = '0;
        end
        fir_pkg::CMD_FILTER: begin
          // taps above the line length behave as the full line
          taps = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
          history[wr_slot] = smp;
          acc = 0;
          for (int j = 0; j < taps; j++) begin
            slot = wr_slot - INDEX_W'(j);
            acc += longint'(history[slot]) * longint'(coefs[j]);
          end
          wr_slot++;
          // single floor shift of the exact sum, then clip
          y = acc >>> COEF_FRAC_BITS;
          res.sat = 1'b0;
          if (y > OUT_MAX) begin
            y = OUT_MAX;
            res.sat = 1'b1;
          end else if (y < OUT_MIN) begin
            y = OUT_MIN;
            res.sat = 1'b1;
          end
          res.value = y[SAMPLE_W-1:0];
          expected_outputs = {expected_outputs, res};
        end
        default: ;
      endcase
    endfunction

    // compare one output transfer with the oldest prediction
    function void check_output(logic signed [SAMPLE_W-1:0] value, logic sat);
      fir_out_t exp_r;
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: output with none pending: filtered_sample %0d saturated %0b",
                 $time, value, sat);
      end else begin
        exp_r = expected_outputs.pop_front();
        if (value !== exp_r.value) begin
          errors++;
          $display("%0t: filtered_sample expected %0d actual %0d",
                   $time, exp_r.value, value);
        end
        if (sat !== exp_r.sat) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.sat, sat);
        end
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  longint cycles;

  fir_output_predictor sb;

  fir_in_if  in_if ();
  fir_cfg_if cfg_if ();
  fir_out_if out_if ();

  fir_filter_audio #(
    .MAX_TAPS      (MAX_TAPS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(in_if),
    .cfg_i   (cfg_if),
    .result_o(out_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // output side: random stalls and checking of each transfer
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        sb.check_output(out_if.filtered_sample, out_if.saturated);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
                           logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] coef);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.sample      <= smp;
    in_if.tap_index   <= idx;
    in_if.coefficient <= coef;
    do @(posedge clk_i); while (!in_if.ready);
    sb.accept_item(cmd, smp, idx, coef);
  endtask

  task automatic filter_sample(logic signed [SAMPLE_W-1:0] smp);
    send_item(fir_pkg::CMD_FILTER, smp, INDEX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic load_coef(logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] coef);
    send_item(fir_pkg::CMD_LOAD, SAMPLE_W'($urandom), idx, coef);
  endtask

  // tap count write, only once the filter has drained
  task automatic write_tap_count(logic [TAPCNT_W-1:0] v);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_taps(v);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly filtering with occasional loads, clears and unused commands
  task automatic random_items(int n);
    int                         pick;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [COEF_W-1:0]   coef;
    logic [INDEX_W-1:0]         idx;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      idx  = INDEX_W'($urandom);
      if ($urandom_range(9) == 0) smp = $urandom_range(1) ? SMP_POS_MAX : SMP_NEG_MAX;
      else smp = SAMPLE_W'($urandom);
      if ($urandom_range(4) < 2) coef = COEF_W'($urandom);
      else coef = COEF_W'(int'($urandom_range(4095)) - 2048);
      if (pick < 82) send_item(fir_pkg::CMD_FILTER, smp, idx, coef);
      else if (pick < 96) send_item(fir_pkg::CMD_LOAD, smp, idx, coef);
      else if (pick < 98) send_item(fir_pkg::CMD_CLEAR, smp, idx, coef);
      else send_item(CMD_UNUSED, smp, idx, coef);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= '0;
    in_if.sample      <= '0;
    in_if.tap_index   <= '0;
    in_if.coefficient <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty tap set gives zero
    write_tap_count(7'd0);
    filter_sample(SMP_POS_MAX);
    write_tap_count(7'd1);

    // full-scale coefficients push the output onto both rails
    load_coef(6'd0, COEF_POS_MAX);
    filter_sample(SMP_POS_MAX);
    filter_sample(SMP_NEG_MAX);
    load_coef(6'd0, COEF_NEG_MAX);
    filter_sample(SMP_POS_MAX);
    filter_sample(SMP_NEG_MAX);

    // unity gain passes samples through
    load_coef(6'd0, COEF_UNITY);
    filter_sample(16'sd12345);
    filter_sample(-16'sd1);
    filter_sample(16'sd0);

    // floor of small negative and positive sums
    load_coef(6'd0, COEF_NEG_LSB);
    filter_sample(16'sd1);
    filter_sample(-16'sd1);

    // clear drops the older sample from a two-tap sum
    load_coef(6'd0, COEF_UNITY);
    load_coef(6'd1, COEF_UNITY);
    write_tap_count(7'd2);
    filter_sample(16'sd1000);
    send_item(fir_pkg::CMD_CLEAR, SAMPLE_W'($urandom), INDEX_W'($urandom),
              COEF_W'($urandom));
    filter_sample(16'sd7);
    send_item(CMD_UNUSED, SAMPLE_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom));
    filter_sample(16'sd3);

    // fill the whole coefficient store before using more taps
    for (int t = 0; t < MAX_TAPS; t++) begin
      load_coef(INDEX_W'(t), COEF_W'(int'($urandom_range(8191)) - 4096));
    end

    // no idling, full line
    write_tap_count(7'd64);
    random_items(PHASE_ITEMS);

    // sender mostly idle, single tap
    send_idle_pct  = 86;
    recv_stall_pct = 0;
    write_tap_count(7'd1);
    random_items(PHASE_ITEMS);

    // receiver mostly stalled, tap count beyond the line
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    write_tap_count(7'd127);
    random_items(PHASE_ITEMS);

    // light idling on both sides, random tap count
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    write_tap_count(TAPCNT_W'($urandom_range(63, 2)));
    random_items(PHASE_ITEMS);

    // drain
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
